// ===== rtl/core/stc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// stc_pkg: shared types, constants and palette ROM for the colormap block
// Holds the register indexes, the palette table and the configuration struct.
// ----------------------------------------------------------------------------
package stc_pkg;

  localparam int unsigned SampleW   = 20;
  localparam int unsigned FracBitsD = 16;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 24;
  localparam int unsigned RomDepth  = 200;
  localparam int unsigned RomAddrW  = 8;
  localparam int unsigned SegW      = 5;

  localparam logic [CfgIdxW-1:0] REG_MAP_MODE = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_INTERP   = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_INVERT   = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_NEGATE   = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_CONST    = 3'd4;

  localparam logic [3:0] MODE_CONST = 4'd15;
  localparam logic [7:0] GREY_LEVEL = 8'd180;

  // configuration registers
  typedef struct packed {
    logic [3:0]  map_mode;
    logic        interp_enable;
    logic        invert_enable;
    logic        negate_enable;
    logic [23:0] const_color;
  } cfg_t;

  // palette entry count per mode
  function automatic logic [5:0] pal_count(input logic [3:0] m);
    logic [5:0] c;
    case (m)
      4'd0, 4'd1, 4'd2, 4'd9: c = 6'd5;
      4'd3, 4'd4, 4'd8:       c = 6'd3;
      4'd5:                   c = 6'd8;
      4'd6:                   c = 6'd32;
      4'd7:                   c = 6'd9;
      4'd10, 4'd11, 4'd12, 4'd13: c = 6'd30;
      default:                c = 6'd2;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] pal_base(input logic [3:0] m);
    logic [7:0] b;
    case (m)
      4'd0: b = 8'd0;    4'd1: b = 8'd5;    4'd2: b = 8'd10;   4'd3: b = 8'd15;
      4'd4: b = 8'd18;   4'd5: b = 8'd21;   4'd6: b = 8'd29;   4'd7: b = 8'd61;
      4'd8: b = 8'd70;   4'd9: b = 8'd73;   4'd10: b = 8'd78;  4'd11: b = 8'd108;
      4'd12: b = 8'd138; 4'd13: b = 8'd168; default: b = 8'd198;
    endcase
    return b;
  endfunction

  localparam logic [23:0] PAL_ROM [RomDepth] = '{
    24'h0000FF, 24'h7F007F, 24'hFF0000, 24'hFF7F00, 24'hFFFF55,
    24'h0000FF, 24'hFF00FF, 24'hFF0000, 24'hFFFF00, 24'h00FF00,
    24'h00007F, 24'h550040, 24'hAA0000, 24'hFF7F00, 24'hFFFF00,
    24'hFF7F00, 24'h7F007F, 24'h007FFF,
    24'h0000FF, 24'hFFFF00, 24'hFF0000,
    24'h00008B, 24'h0000FF, 24'h00FFFF, 24'h00FF00, 24'hFFFF00, 24'hFF0000,
    24'h8B0000, 24'h000000,
    24'h0000FF, 24'h005CFF, 24'h0082FF, 24'h009FFF, 24'h00B7FF, 24'h00CDFF,
    24'h00E0FF, 24'h00F2FF, 24'h00FFFB, 24'h00FFEA, 24'h00FFD7, 24'h00FFC2,
    24'h00FFAB, 24'h00FF91, 24'h00FF70, 24'h00FF41, 24'h41FF00, 24'h70FF00,
    24'h91FF00, 24'hABFF00, 24'hC2FF00, 24'hD7FF00, 24'hEAFF00, 24'hFBFF00,
    24'hFFF200, 24'hFFE000, 24'hFFCD00, 24'hFFB700, 24'hFF9F00, 24'hFF8200,
    24'hFF5C00, 24'hFF0000,
    24'h000080, 24'h0000FF, 24'h0080FF, 24'h00FFFF, 24'h80FF80, 24'hFFFF00,
    24'hFF8000, 24'hFF0000, 24'h800000,
    24'h0000FF, 24'hFFFFFF, 24'hFF0000,
    24'h00004C, 24'h0000FF, 24'hFFFFFF, 24'hFF0000, 24'h7F0000,
    24'hFDE725, 24'hEAE51A, 24'hD2E21B, 24'hBADE28, 24'hA2DA37, 24'h8BD646,
    24'h77D153, 24'h63CB5F, 24'h50C46A, 24'h3FBC73, 24'h31B57B, 24'h26AD81,
    24'h21A585, 24'h1E9D89, 24'h1F948C, 24'h228C8D, 24'h25838E, 24'h297B8E,
    24'h2C738E, 24'h2F6B8E, 24'h33628D, 24'h38598C, 24'h3C4F8A, 24'h404588,
    24'h443B84, 24'h46307E, 24'h482576, 24'h481A6C, 24'h470D60, 24'h440154,
    24'hFCFFA4, 24'hF3F586, 24'hF2E661, 24'hF6D543, 24'hFAC42A, 24'hFCB216,
    24'hFCA309, 24'hFA9207, 24'hF78212, 24'hF1731D, 24'hEB6429, 24'hE25734,
    24'hD94D3D, 24'hCE4347, 24'hC13A50, 24'hB43359, 24'hA62D60, 24'h982766,
    24'h8C2369, 24'h7D1E6D, 24'h6F196E, 24'h61136E, 24'h520E6D, 24'h440A68,
    24'h360961, 24'h260C51, 24'h180C3C, 24'h0C0826, 24'h040312, 24'h000004,
    24'hFCFDBF, 24'hFCEEB0, 24'hFDDEA0, 24'hFECD90, 24'hFEBD82, 24'hFEAC76,
    24'hFE9D6C, 24'hFC8C63, 24'hF97B5D, 24'hF56B5C, 24'hEE5B5E, 24'hE44F64,
    24'hD9466B, 24'hCC3F71, 24'hBD3977, 24'hAE347B, 24'hA02F7F, 24'h912B81,
    24'h842681, 24'h762181, 24'h681C81, 24'h5A167E, 24'h4C117A, 24'h3D0F71,
    24'h2F1163, 24'h21114E, 24'h150E38, 24'h0B0924, 24'h030312, 24'h000004,
    24'hF0F921, 24'hF5EB27, 24'hF9DC24, 24'hFCCD25, 24'hFEBE2A, 24'hFDB130,
    24'hFCA537, 24'hF9983E, 24'hF58C46, 24'hF0804E, 24'hEB7556, 24'hE56A5D,
    24'hDE6164, 24'hD7566C, 24'hCF4C74, 24'hC7427C, 24'hBE3885, 24'hB42E8D,
    24'hAB2494, 24'hA01A9C, 24'h9410A2, 24'h8707A6, 24'h7A02A8, 24'h6C00A8,
    24'h6001A6, 24'h5102A3, 24'h43039E, 24'h330597, 24'h220690, 24'h0D0887,
    24'h000000, 24'hFFFFFF
  };

endpackage

`default_nettype wire

// ===== rtl/core/scalar_to_rgb_colormap.sv =====
`default_nettype none
// Path: an accepted sample word is registered in the front stage, then in the back stage.
// Throughput: one word per cycle while m_axis_tready is high; front and back stages each hold one word.
// Reset: asynchronous, active low; clears valid flags and loads register
// defaults (mode 0, interpolation on, constant color white).
// ----------------------------------------------------------------------------
// scalar_to_rgb_colormap: scalar sample to RGB pseudocolor mapper
// Stream in, stream out, with a small register write channel.
// ----------------------------------------------------------------------------
module scalar_to_rgb_colormap
  import stc_pkg::*;
#(
  parameter int unsigned FRAC_BITS = FracBitsD
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  input  wire logic [23:0]         s_axis_tdata,  // sample_value[19:0], zero pad
  input  wire logic                s_axis_tuser,  // no_data
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  output logic [23:0]              m_axis_tdata   // blue [23:16], green, red [7:0]
);

  cfg_t cfg_q;
  logic q_valid, q_ready, q_nodata, q_last;
  logic [RomAddrW-1:0] q_addr;
  logic [FRAC_BITS-1:0] q_frac;

  assign cfg_ready_o = 1'b1;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.map_mode      <= 4'd0;
      cfg_q.interp_enable <= 1'b1;
      cfg_q.invert_enable <= 1'b0;
      cfg_q.negate_enable <= 1'b0;
      cfg_q.const_color   <= 24'hFFFFFF;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_MAP_MODE: cfg_q.map_mode      <= cfg_data_i[3:0];
        REG_INTERP:   cfg_q.interp_enable <= cfg_data_i[0];
        REG_INVERT:   cfg_q.invert_enable <= cfg_data_i[0];
        REG_NEGATE:   cfg_q.negate_enable <= cfg_data_i[0];
        REG_CONST:    cfg_q.const_color   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  stc_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk_i, .rst_ni, .cfg_i(cfg_q),
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .sample_i(s_axis_tdata[SampleW-1:0]), .no_data_i(s_axis_tuser),
    .q_valid_o(q_valid), .q_ready_i(q_ready), .q_nodata_o(q_nodata),
    .q_last_o(q_last), .q_addr_o(q_addr), .q_frac_o(q_frac)
  );

  stc_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk_i, .rst_ni, .cfg_i(cfg_q),
    .q_valid_i(q_valid), .q_ready_o(q_ready), .q_nodata_i(q_nodata),
    .q_last_i(q_last), .q_addr_i(q_addr), .q_frac_i(q_frac),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .out_data_o(m_axis_tdata)
  );

endmodule

`default_nettype wire

// ===== rtl/core/stc_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// stc_front: sample conditioning and palette address generation
// Inverts, clamps or quantizes the sample and forms segment and fraction.
// ----------------------------------------------------------------------------
module stc_front
  import stc_pkg::*;
#(
  parameter int unsigned FRAC_BITS = FracBitsD
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire cfg_t                 cfg_i,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic [SampleW-1:0]   sample_i,
  input  wire logic                 no_data_i,
  output logic                      q_valid_o,
  input  wire logic                 q_ready_i,
  output logic                      q_nodata_o,
  output logic                      q_last_o,
  output logic [RomAddrW-1:0]       q_addr_o,
  output logic [FRAC_BITS-1:0]      q_frac_o
);

  // wide enough for the sample and for one - sample at any fraction width
  localparam int unsigned VW = ((SampleW > FRAC_BITS) ? SampleW : FRAC_BITS) + 2;
  localparam int unsigned PW = VW + 6;
  localparam logic signed [VW-1:0] One = VW'(1) <<< FRAC_BITS;
  localparam logic signed [VW-1:0] Eighth = One >>> 3;

  logic signed [VW-1:0] v_raw, v_c;
  logic [PW-1:0] pos;
  logic [5:0] n;
  logic [SegW:0] seg;
  logic last;

  // one-entry handoff register
  logic valid_q;
  logic nodata_q, last_q;
  logic [RomAddrW-1:0] addr_q;
  logic [FRAC_BITS-1:0] frac_q;

  always_comb begin
    v_raw = VW'($signed(sample_i));
    if (cfg_i.invert_enable) v_raw = One - v_raw;
    if (cfg_i.interp_enable) begin
      if (v_raw < 0) v_c = '0;
      else if (v_raw > One) v_c = One;
      else v_c = v_raw;
    end else begin
      if (v_raw < Eighth) v_c = '0;
      else if (v_raw < 3 * Eighth) v_c = One >>> 2;
      else if (v_raw < 5 * Eighth) v_c = One >>> 1;
      else if (v_raw < 7 * Eighth) v_c = 3 * (One >>> 2);
      else v_c = One;
    end
    n    = pal_count(cfg_i.map_mode);
    pos  = PW'(n - 6'd1) * PW'(unsigned'(v_c));
    seg  = (SegW+1)'(pos >> FRAC_BITS);
    last = (seg >= (n - 6'd1));
  end

  assign in_ready_o = !valid_q || q_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      nodata_q <= no_data_i;
      last_q   <= last;
      addr_q   <= last ? pal_base(cfg_i.map_mode) + RomAddrW'(n - 6'd1)
                       : pal_base(cfg_i.map_mode) + RomAddrW'(seg);
      frac_q   <= pos[FRAC_BITS-1:0];
    end
  end

  assign q_valid_o  = valid_q;
  assign q_nodata_o = nodata_q;
  assign q_last_o   = last_q;
  assign q_addr_o   = addr_q;
  assign q_frac_o   = frac_q;

endmodule

`default_nettype wire

// ===== rtl/core/stc_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// stc_back: palette lookup, interpolation and output stage
// Blends two neighbor entries per channel, applies constant mode, negation and no-data grey.
// ----------------------------------------------------------------------------
module stc_back
  import stc_pkg::*;
#(
  parameter int unsigned FRAC_BITS = FracBitsD
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire cfg_t                 cfg_i,
  input  wire logic                 q_valid_i,
  output logic                      q_ready_o,
  input  wire logic                 q_nodata_i,
  input  wire logic                 q_last_i,
  input  wire logic [RomAddrW-1:0]  q_addr_i,
  input  wire logic [FRAC_BITS-1:0] q_frac_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic [23:0]               out_data_o
);

  localparam int unsigned NW = FRAC_BITS + 10;

  logic [23:0] e0, e1, pix;
  logic [7:0]  ch [3];
  logic valid_q;
  logic [23:0] data_q;

  always_comb begin
    e0 = PAL_ROM[q_addr_i];
    e1 = (q_addr_i == RomAddrW'(RomDepth - 1)) ? e0 : PAL_ROM[q_addr_i + 1'b1];
    for (int c = 0; c < 3; c++) begin
      logic signed [NW-1:0] a, d, num;
      a   = NW'(e0[c*8 +: 8]);
      d   = NW'(e1[c*8 +: 8]) - a;
      num = (a <<< FRAC_BITS) + $signed({1'b0, q_frac_i}) * d;
      ch[c] = q_last_i ? e0[c*8 +: 8] : num[FRAC_BITS +: 8];
    end
    pix = {ch[2], ch[1], ch[0]};
    if (cfg_i.map_mode == MODE_CONST) pix = cfg_i.const_color;
    if (cfg_i.negate_enable) pix = ~pix;
    if (q_nodata_i) pix = {3{GREY_LEVEL}};
  end

  assign q_ready_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (q_ready_o) begin
      valid_q <= q_valid_i;
    end
  end

  // output word: red in the lowest byte
  always_ff @(posedge clk_i) begin
    if (q_ready_o && q_valid_i) begin
      data_q <= {pix[7:0], pix[15:8], pix[23:16]};
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

`default_nettype wire
